// File: sv/mffs_pkg.sv
`timescale 1ns / 1ps

package mffs_pkg;

    // Iteration counts of the arithmetic pipelines.
    localparam int LOG_BITS = 24;
    localparam int EXP_BITS = 24;
    localparam int QUOT_W   = 38;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] RECIP3    = 32'hAAAAAAAB;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ABSORB_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ABSORB_GREEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABSORB_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCATTER_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCATTER_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCATTER_BLUE  = 3'd5;
    localparam logic [23:0] COEF_RESET = 24'd65536;

    typedef logic [24:0] ext_t;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [30:0]        seg_start;
        logic [30:0]        seg_end;
        logic [31:0]        uniform_sample;
        logic [1:0]         channel_pick;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [30:0]        hit_t;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [23:0]        density;
        logic [16:0]        trans_red;
        logic [16:0]        trans_green;
        logic [16:0]        trans_blue;
    } rsp_t;

    // Classified ray handed from the front to the back.
    typedef struct packed {
        logic             operation;
        logic             cand;
        logic [30:0]      t;
        logic [30:0]      d;
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
    } work_t;

    // Root of one half after idx+1 successive square roots, Q0.32.
    function automatic logic [31:0] exp_root(input int idx);
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        r = 64'h8000_0000;
        for (int j = 0; j <= idx; j++) begin
            v     = r << 32;
            res   = 64'd0;
            bit_v = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (v >= res + bit_v) begin
                    v   = v - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
            r = res;
        end
        return r[31:0];
    endfunction

endpackage

// File: sv/mffs_queue.sv
`timescale 1ns / 1ps

module mffs_queue
    import mffs_pkg::*;
#(
    parameter int DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output work_t head,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    work_t           entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a write");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count missed a read");

endmodule

// File: sv/mffs_front.sv
`timescale 1ns / 1ps

module mffs_front
    import mffs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req_data,
    input  ext_t [2:0] ext,
    output logic       push,
    output work_t      push_data,
    input  logic       full
);

    // Stage map: input, leading one, normalize, squarings, log scale,
    // quotient bits, classify.
    localparam int S_K  = 1;
    localparam int S_M  = 2;
    localparam int S_SQ = 3;
    localparam int S_NL = S_SQ + LOG_BITS;
    localparam int S_DV = S_NL + 1;
    localparam int S_CL = S_DV + QUOT_W;

    typedef struct packed {
        req_t        req;
        logic [32:0] w;
        logic [5:0]  k;
        logic [31:0] m;
        logic [23:0] f;
        ext_t        dv;
        logic [24:0] rem;
        logic [37:0] nq;
    } fr_t;

    logic [S_CL:0] valid_reg;
    fr_t           st_reg  [S_CL];
    fr_t           st_next [S_CL];
    work_t         cls_reg, cls_next;
    logic          en;

    assign en        = !(valid_reg[S_CL] && full);
    assign req_ready = en;
    assign push      = valid_reg[S_CL] && !full;
    assign push_data = cls_reg;

    for (genvar s = 0; s < S_CL; s++)
    begin : g_st
        fr_t nx;
        if (s == 0)
        begin : g_in
            always_comb
            begin
                nx     = '0;
                nx.req = req_data;
                nx.w   = ONE_Q32 - {1'b0, req_data.uniform_sample};
            end
        end else if (s == S_K)
        begin : g_lead
            always_comb
            begin
                nx   = st_reg[s-1];
                nx.k = '0;
                for (int b = 0; b < 33; b++)
                begin
                    if (st_reg[s-1].w[b])
                    begin
                        nx.k = 6'(b);
                    end
                end
            end
        end else if (s == S_M)
        begin : g_norm
            always_comb
            begin
                nx = st_reg[s-1];
                if (st_reg[s-1].k[5])
                begin
                    nx.m = st_reg[s-1].w[32:1];
                end else
                begin
                    nx.m = st_reg[s-1].w[31:0] << (5'd31 - st_reg[s-1].k[4:0]);
                end
                nx.f = '0;
            end
        end else if (s < S_NL)
        begin : g_sq
            always_comb
            begin
                logic [63:0] sq;
                logic [32:0] sh;
                nx = st_reg[s-1];
                sq = {32'd0, st_reg[s-1].m} * {32'd0, st_reg[s-1].m};
                sh = sq[63:31];
                if (sh[32])
                begin
                    nx.m = sh[32:1];
                    nx.f = {st_reg[s-1].f[22:0], 1'b1};
                end else
                begin
                    nx.m = sh[31:0];
                    nx.f = {st_reg[s-1].f[22:0], 1'b0};
                end
            end
        end else if (s == S_NL)
        begin : g_nl
            always_comb
            begin
                logic [29:0] nl2;
                logic [61:0] prod;
                logic [1:0]  psel;
                nx   = st_reg[s-1];
                nl2  = {6'(6'd32 - st_reg[s-1].k), 24'd0} - {6'd0, st_reg[s-1].f};
                prod = {32'd0, nl2} * {30'd0, LN2_Q32};
                psel = (st_reg[s-1].req.channel_pick == 2'd3) ? 2'd2
                                                              : st_reg[s-1].req.channel_pick;
                nx.nq  = prod[61:24];
                nx.rem = '0;
                nx.dv  = ext[psel];
            end
        end else
        begin : g_div
            always_comb
            begin
                logic [25:0] tr;
                logic        ge;
                nx = st_reg[s-1];
                tr = {st_reg[s-1].rem, st_reg[s-1].nq[37]};
                ge = (tr >= {1'b0, st_reg[s-1].dv});
                nx.rem = ge ? 25'(tr - {1'b0, st_reg[s-1].dv}) : tr[24:0];
                nx.nq  = {st_reg[s-1].nq[36:0], ge};
            end
        end
        assign st_next[s] = nx;
    end

    always_comb
    begin
        fr_t         p;
        logic [30:0] len;
        logic        short_d;
        p       = st_reg[S_CL-1];
        len     = (p.req.seg_end >= p.req.seg_start) ? p.req.seg_end - p.req.seg_start
                                                     : 31'd0;
        short_d = (p.dv != '0) && (p.nq < {7'd0, len});
        cls_next.operation = p.req.operation;
        cls_next.cand      = !p.req.operation && short_d;
        cls_next.d         = (!p.req.operation && short_d) ? p.nq[30:0] : len;
        cls_next.t         = p.nq[30:0] + p.req.seg_start;
        cls_next.org       = {p.req.origin_z, p.req.origin_y, p.req.origin_x};
        cls_next.dir       = {p.req.dir_z, p.req.dir_y, p.req.dir_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end else if (en)
        begin
            valid_reg <= {valid_reg[S_CL-1:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < S_CL; s++)
            begin
                st_reg[s] <= st_next[s];
            end
            cls_reg <= cls_next;
        end
    end

endmodule

// File: sv/mffs_back.sv
`timescale 1ns / 1ps

module mffs_back
    import mffs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ext_t [2:0] ext,
    input  work_t      head,
    input  logic       empty,
    output logic       pop,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp_data
);

    // Stage map: products, point, log2e scale, split, exponent factors,
    // shift, density sum, density select, output.
    localparam int B_PT  = 1;
    localparam int B_LG  = 2;
    localparam int B_SP  = 3;
    localparam int B_EX  = 4;
    localparam int B_SH  = B_EX + EXP_BITS;
    localparam int B_SUM = B_SH + 1;
    localparam int B_V   = B_SUM + 1;
    localparam int B_OUT = B_V + 1;

    localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
    localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

    typedef struct packed {
        logic             operation;
        logic             cand;
        logic [30:0]      t;
        logic [2:0][31:0] org;
        logic [2:0][63:0] p;
        logic [2:0][55:0] x;
        logic [2:0][31:0] pt;
        logic             same;
        logic [2:0]       zero;
        logic [2:0][28:0] xs;
        logic [2:0][29:0] y;
        logic [2:0][4:0]  n;
        logic [2:0][23:0] f;
        logic [2:0][32:0] acc;
        logic             hit;
        logic [59:0]      sum;
        logic [27:0]      v;
    } bk_t;

    logic [B_OUT:0] valid_reg;
    bk_t            st_reg  [B_OUT];
    bk_t            st_next [B_OUT];
    rsp_t           out_reg, out_next;
    logic           en;

    assign en        = !valid_reg[B_OUT] || rsp_ready;
    assign pop       = en && !empty;
    assign rsp_valid = valid_reg[B_OUT];
    assign rsp_data  = out_reg;

    for (genvar s = 0; s < B_OUT; s++)
    begin : g_st
        bk_t nx;
        if (s == 0)
        begin : g_mul
            always_comb
            begin
                nx           = '0;
                nx.operation = head.operation;
                nx.cand      = head.cand;
                nx.t         = head.t;
                nx.org       = head.org;
                for (int c = 0; c < 3; c++)
                begin
                    nx.x[c] = 56'(ext[c]) * 56'(head.d);
                    nx.p[c] = 64'($signed({1'b0, head.t})) * 64'($signed(head.dir[c]));
                end
            end
        end else if (s == B_PT)
        begin : g_pt
            always_comb
            begin
                logic signed [48:0] sm;
                nx = st_reg[s-1];
                for (int c = 0; c < 3; c++)
                begin
                    sm = 49'($signed(st_reg[s-1].p[c][63:16]))
                       + 49'($signed(st_reg[s-1].org[c]));
                    if (sm > SAT_HI)
                    begin
                        nx.pt[c] = 32'h7FFF_FFFF;
                    end else if (sm < SAT_LO)
                    begin
                        nx.pt[c] = 32'h8000_0000;
                    end else
                    begin
                        nx.pt[c] = sm[31:0];
                    end
                    nx.zero[c] = (st_reg[s-1].x[c][55:37] != '0);
                    nx.xs[c]   = st_reg[s-1].x[c][36:8];
                end
            end
        end else if (s == B_LG)
        begin : g_lg
            always_comb
            begin
                logic [59:0] pr;
                nx      = st_reg[s-1];
                nx.same = (st_reg[s-1].pt == st_reg[s-1].org);
                for (int c = 0; c < 3; c++)
                begin
                    pr       = 60'(st_reg[s-1].xs[c]) * 60'(LOG2E_Q30);
                    nx.y[c]  = pr[59:30];
                end
            end
        end else if (s == B_SP)
        begin : g_sp
            always_comb
            begin
                nx = st_reg[s-1];
                for (int c = 0; c < 3; c++)
                begin
                    nx.zero[c] = st_reg[s-1].zero[c] | st_reg[s-1].y[c][29];
                    nx.n[c]    = st_reg[s-1].y[c][28:24];
                    nx.f[c]    = st_reg[s-1].y[c][23:0];
                    nx.acc[c]  = ONE_Q32;
                end
            end
        end else if (s < B_SH)
        begin : g_ex
            localparam logic [31:0] ROOT = exp_root(s - B_EX);
            always_comb
            begin
                logic [64:0] pr;
                nx = st_reg[s-1];
                for (int c = 0; c < 3; c++)
                begin
                    pr = 65'(st_reg[s-1].acc[c]) * 65'(ROOT);
                    if (st_reg[s-1].f[c][EXP_BITS-1-(s-B_EX)])
                    begin
                        nx.acc[c] = pr[64:32];
                    end
                end
            end
        end else if (s == B_SH)
        begin : g_sh
            always_comb
            begin
                nx = st_reg[s-1];
                for (int c = 0; c < 3; c++)
                begin
                    nx.acc[c] = st_reg[s-1].zero[c] ? 33'd0
                                                    : st_reg[s-1].acc[c] >> st_reg[s-1].n[c];
                end
            end
        end else if (s == B_SUM)
        begin : g_sum
            always_comb
            begin
                logic hit_c;
                nx     = st_reg[s-1];
                hit_c  = st_reg[s-1].cand && !st_reg[s-1].same;
                nx.hit = hit_c;
                nx.sum = '0;
                for (int c = 0; c < 3; c++)
                begin
                    if (hit_c)
                    begin
                        nx.sum = nx.sum + 60'(st_reg[s-1].acc[c]) * 60'(ext[c]);
                    end else
                    begin
                        nx.sum = nx.sum + 60'(st_reg[s-1].acc[c]);
                    end
                end
            end
        end else
        begin : g_v
            always_comb
            begin
                nx   = st_reg[s-1];
                nx.v = st_reg[s-1].hit ? st_reg[s-1].sum[59:32] : st_reg[s-1].sum[43:16];
            end
        end
        assign st_next[s] = nx;
    end

    always_comb
    begin
        bk_t         p;
        logic [59:0] qm;
        logic [26:0] q;
        p  = st_reg[B_OUT-1];
        qm = 60'(p.v) * 60'(RECIP3);
        q  = qm[59:33];
        out_next.hit         = p.hit;
        out_next.hit_t       = p.hit ? p.t : 31'd0;
        out_next.point_x     = p.hit ? p.pt[0] : 32'd0;
        out_next.point_y     = p.hit ? p.pt[1] : 32'd0;
        out_next.point_z     = p.hit ? p.pt[2] : 32'd0;
        if (p.operation)
        begin
            out_next.density = 24'd0;
        end else if (q[26:24] != '0)
        begin
            out_next.density = 24'hFF_FFFF;
        end else
        begin
            out_next.density = q[23:0];
        end
        out_next.trans_red   = p.acc[0][32:16];
        out_next.trans_green = p.acc[1][32:16];
        out_next.trans_blue  = p.acc[2][32:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end else if (en)
        begin
            valid_reg <= {valid_reg[B_OUT-1:0], !empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < B_OUT; s++)
            begin
                st_reg[s] <= st_next[s];
            end
            out_reg <= out_next;
        end
    end

endmodule

// File: sv/medium_free_flight_sampler.sv
`timescale 1ns / 1ps

// Free-flight sampler for a homogeneous medium, fully pipelined.
// Requests arrive on req_valid/req_ready/req_data, one ray per request, and
// each request produces exactly one response on rsp_valid/rsp_ready/rsp_data,
// in request order. Absorption and scattering coefficients are written on
// the cfg_valid/cfg_ready/cfg_index/cfg_data port, which is always ready;
// indexes past the last register are dropped. Write them only while idle.
// Throughput is one request per cycle while the receiver keeps up. The
// front pipeline (leading-one detect, 24 squaring steps of the log, one
// quotient bit per stage of the distance divide, classification) feeds
// the queue; the back pipeline (products, point, 24 exponent factor
// stages, density) drains it. When the receiver stalls, the back pipeline
// holds while the queue between the halves absorbs QUEUE_DEPTH requests,
// after which the front holds and req_ready falls. Reset clears all valid
// state and loads every coefficient with 1.0; no clearing pass is needed.

module medium_free_flight_sampler
    import mffs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data
);

    logic [23:0] absorb_reg  [3];
    logic [23:0] scatter_reg [3];
    ext_t [2:0]  ext;

    logic  push, full, pop, empty;
    work_t push_data, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                absorb_reg[c]  <= COEF_RESET;
                scatter_reg[c] <= COEF_RESET;
            end
        end else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ABSORB_RED:    absorb_reg[0]  <= cfg_data;
                REG_ABSORB_GREEN:  absorb_reg[1]  <= cfg_data;
                REG_ABSORB_BLUE:   absorb_reg[2]  <= cfg_data;
                REG_SCATTER_RED:   scatter_reg[0] <= cfg_data;
                REG_SCATTER_GREEN: scatter_reg[1] <= cfg_data;
                REG_SCATTER_BLUE:  scatter_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Extinction per channel is the plain sum of the two coefficients.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ext[c] = 25'(absorb_reg[c]) + 25'(scatter_reg[c]);
        end
    end

    mffs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .ext       (ext),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    mffs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    mffs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ext       (ext),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule
